// File: src/region_thread_count_search_assert.svh
// Assertion macros shared by the checker of the region thread-count search.
// Needs a clock named clk and a reset named rst in the scope of each use.
`ifndef REGION_THREAD_COUNT_SEARCH_ASSERT_SVH
`define REGION_THREAD_COUNT_SEARCH_ASSERT_SVH

// Same-cycle implication, switched off during reset.
`define RTCS_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rtcs check failed");

// Next-cycle implication, switched off during reset.
`define RTCS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rtcs check failed");

`endif

// File: src/rtcs_pkg.sv
// Types, constants and helper functions of the region thread-count search.
// Used by the slot cell, the controller, the top level and the checker.
`default_nettype none

package rtcs_pkg;

  localparam int REGION_SLOTS = 64;
  localparam int SLOT_W       = $clog2(REGION_SLOTS);
  localparam int CNT_W        = $clog2(REGION_SLOTS + 1);
  localparam int KEY_W        = 48;
  localparam int THR_W        = 10;
  localparam int CORE_W       = 9;
  localparam int VAL_W        = 32;
  localparam int SCORE_W      = 64;
  localparam int SLOT_OUT_W   = 6;

  // Configuration register indexes.
  localparam logic CFG_CORE_COUNT = 1'b0;
  localparam logic CFG_SCORE_MODE = 1'b1;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_REPEAT = 3'd1,
    PH_S0     = 3'd2,
    PH_S1     = 3'd3,
    PH_S2     = 3'd4,
    PH_S3     = 3'd5,
    PH_END    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH_SEARCH,
    ST_SEARCH,
    ST_LAUNCH_UPDATE,
    ST_UPDATE,
    ST_DELIVER
  } ctrl_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] region_key;
    logic [VAL_W-1:0] elapsed_time;
    logic [VAL_W-1:0] energy_used;
  } in_item_t;

  typedef struct packed {
    logic [THR_W-1:0]      thread_count;
    logic [SLOT_OUT_W-1:0] region_slot;
    logic                  table_full;
  } out_item_t;

  // Token that walks down the row of slot cells.
  typedef struct packed {
    logic               vld;
    logic               upd;
    logic [KEY_W-1:0]   key;
    logic               found;
    logic [SLOT_W-1:0]  cur_slot;
    logic [SLOT_W-1:0]  prior_slot;
    logic               prior_valid;
    logic               do_score;
    logic [VAL_W-1:0]   time_val;
    logic [SCORE_W-1:0] prod_val;
    logic [THR_W-1:0]   result;
  } token_t;

  // Settings broadcast from the controller to every cell.
  typedef struct packed {
    logic [CORE_W-1:0] core_count;
    logic              score_mode;
    logic [CNT_W-1:0]  used_slots;
    logic [THR_W-1:0]  start_threads;
  } bcast_t;

  // Halve the core count until it is 2, 3 or 5; 1 if it drops below 2.
  function automatic logic [THR_W-1:0] start_count(input logic [CORE_W-1:0] cores);
    logic [CORE_W-1:0] v;
    logic              done;
    v    = cores;
    done = 1'b0;
    for (int i = 0; i < CORE_W; i++) begin
      if (!done) begin
        if (v == CORE_W'(2) || v == CORE_W'(3) || v == CORE_W'(5)) begin
          done = 1'b1;
        end else if (v < CORE_W'(2)) begin
          v    = CORE_W'(1);
          done = 1'b1;
        end else begin
          v = v >> 1;
        end
      end
    end
    return THR_W'(v);
  endfunction

endpackage

`default_nettype wire

// File: src/rtcs_cell.sv
// One table slot of the region search: key, search phase and counters.
// Depends on rtcs_pkg; takes the token from its left neighbor each cycle.
`default_nettype none

module rtcs_cell
  import rtcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [SLOT_W-1:0] cell_index,
  input  wire bcast_t            bcast,
  input  wire token_t            tok_in,
  output token_t                 tok_out
);

  logic [KEY_W-1:0]   slot_key;
  phase_t             slot_phase;
  logic               slot_mode;
  logic [THR_W-1:0]   slot_threads;
  logic [THR_W-1:0]   slot_last;
  logic [THR_W-1:0]   slot_best;
  logic [THR_W-1:0]   slot_step;
  logic [SCORE_W-1:0] slot_bscore;

  logic [KEY_W-1:0]   slot_key_next;
  phase_t             slot_phase_next;
  logic               slot_mode_next;
  logic [THR_W-1:0]   slot_threads_next;
  logic [THR_W-1:0]   slot_last_next;
  logic [THR_W-1:0]   slot_best_next;
  logic [THR_W-1:0]   slot_step_next;
  logic [SCORE_W-1:0] slot_bscore_next;
  token_t             tok_next;

  logic [SCORE_W-1:0] score;
  logic [THR_W-1:0]   th;
  logic [THR_W:0]     th_dbl;
  logic [THR_W-1:0]   st;
  logic               in_use;

  // Scoring of the region left, then the entry of the region entered.
  always_comb begin
    slot_key_next     = slot_key;
    slot_phase_next   = slot_phase;
    slot_mode_next    = slot_mode;
    slot_threads_next = slot_threads;
    slot_last_next    = slot_last;
    slot_best_next    = slot_best;
    slot_step_next    = slot_step;
    slot_bscore_next  = slot_bscore;
    tok_next          = tok_in;
    score             = {{(SCORE_W-VAL_W){1'b0}}, tok_in.time_val};
    th                = slot_threads;
    th_dbl            = {slot_threads, 1'b0};
    st                = '0;
    in_use            = {1'b0, cell_index} < bcast.used_slots;

    // Search transaction: the first used slot holding the key claims it.
    if (tok_in.vld && !tok_in.upd && !tok_in.found && in_use &&
        slot_key == tok_in.key) begin
      tok_next.found    = 1'b1;
      tok_next.cur_slot = cell_index;
    end

    if (tok_in.vld && tok_in.upd) begin
      // Score the region just left.
      if (tok_in.do_score && cell_index == tok_in.prior_slot &&
          slot_phase != PH_END) begin
        if (slot_mode) begin
          score = tok_in.prod_val;
          if (tok_in.prod_val == '0) begin
            slot_phase_next = PH_REPEAT;
            slot_mode_next  = 1'b0;
          end
        end
        unique case (slot_phase_next)
          PH_REPEAT: begin
            slot_phase_next   = PH_S0;
            slot_threads_next = bcast.start_threads;
            slot_last_next    = bcast.start_threads;
          end
          PH_S0: begin
            slot_bscore_next  = score;
            slot_best_next    = th;
            slot_threads_next = th_dbl[THR_W-1:0];
            slot_phase_next   = PH_S1;
          end
          PH_S1: begin
            st = slot_last >> 1;
            if (score < slot_bscore) begin
              slot_bscore_next = score;
              slot_best_next   = th;
              if (th_dbl <= {2'b00, bcast.core_count}) begin
                slot_last_next    = th;
                slot_threads_next = th_dbl[THR_W-1:0];
                slot_phase_next   = PH_S1;
              end else begin
                slot_threads_next = th - st;
                slot_step_next    = st;
                slot_phase_next   = (st <= THR_W'(1)) ? PH_S3 : PH_S2;
              end
            end else begin
              if (slot_best == {2'b00, bcast.core_count[CORE_W-1:1]}) begin
                slot_threads_next = th - st;
              end else begin
                slot_threads_next = th + st;
              end
              slot_step_next  = st;
              slot_phase_next = (st <= THR_W'(1)) ? PH_S3 : PH_S2;
            end
          end
          PH_S2: begin
            st = slot_step >> 1;
            if (!(slot_bscore < score)) begin
              slot_best_next   = th;
              slot_bscore_next = score;
            end
            slot_threads_next = th + st;
            slot_step_next    = st;
            slot_phase_next   = (st <= THR_W'(1)) ? PH_S3 : PH_S2;
          end
          PH_S3: begin
            if (score < slot_bscore) begin
              slot_best_next = th;
            end
            slot_phase_next = PH_END;
          end
          default: begin
          end
        endcase
      end

      // Enter the region: insert when new, then pick the answer.
      if (cell_index == tok_in.cur_slot) begin
        if (!tok_in.found) begin
          slot_key_next     = tok_in.key;
          slot_phase_next   = PH_START;
          slot_mode_next    = bcast.score_mode;
          slot_threads_next = {1'b0, bcast.core_count};
        end
        if (!tok_in.prior_valid) begin
          slot_phase_next = PH_REPEAT;
          tok_next.result = {1'b0, bcast.core_count};
        end else if (slot_phase_next == PH_END) begin
          tok_next.result = slot_best_next;
        end else if (slot_phase_next == PH_START) begin
          slot_phase_next = PH_REPEAT;
          tok_next.result = {1'b0, bcast.core_count};
        end else begin
          tok_next.result = slot_threads_next;
        end
      end
    end
  end

  // Slot contents are written before they are ever read.
  always_ff @(posedge clk) begin
    slot_key     <= slot_key_next;
    slot_phase   <= slot_phase_next;
    slot_mode    <= slot_mode_next;
    slot_threads <= slot_threads_next;
    slot_last    <= slot_last_next;
    slot_best    <= slot_best_next;
    slot_step    <= slot_step_next;
    slot_bscore  <= slot_bscore_next;
  end

  // Hand the token to the right neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_next.vld;
    end
    tok_out.upd         <= tok_next.upd;
    tok_out.key         <= tok_next.key;
    tok_out.found       <= tok_next.found;
    tok_out.cur_slot    <= tok_next.cur_slot;
    tok_out.prior_slot  <= tok_next.prior_slot;
    tok_out.prior_valid <= tok_next.prior_valid;
    tok_out.do_score    <= tok_next.do_score;
    tok_out.time_val    <= tok_next.time_val;
    tok_out.prod_val    <= tok_next.prod_val;
    tok_out.result      <= tok_next.result;
  end

endmodule

`default_nettype wire

// File: src/rtcs_ctrl.sv
// Controller of the region search: handshakes, configuration, table fill,
// and the launch of search and update transactions into the cell row.
// Depends on rtcs_pkg.
`default_nettype none

module rtcs_ctrl
  import rtcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_index,
  input  wire logic [CORE_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  output bcast_t                 bcast,
  output token_t                 head_tok,
  input  wire token_t            tail_tok
);

  ctrl_state_t        state;
  ctrl_state_t        state_next;
  in_item_t           item;
  logic [SCORE_W-1:0] prod;
  logic               found;
  logic [SLOT_W-1:0]  cur_slot;
  logic [CNT_W-1:0]   used_slots;
  logic [SLOT_W-1:0]  prior_slot;
  logic               prior_valid;
  logic [CORE_W-1:0]  core_count;
  logic               score_mode;
  logic [THR_W-1:0]   start_threads;
  out_item_t          result;
  logic               in_accept;
  logic               out_load;
  logic               table_is_full;

  assign in_stall      = (state != ST_IDLE);
  assign in_accept     = in_valid && !in_stall;
  assign out_load      = (state == ST_DELIVER) && (!out_valid || !out_stall);
  assign table_is_full = (used_slots == CNT_W'(REGION_SLOTS));

  assign bcast.core_count    = core_count;
  assign bcast.score_mode    = score_mode;
  assign bcast.used_slots    = used_slots;
  assign bcast.start_threads = start_threads;

  // Next state and the token driven into the first cell.
  always_comb begin
    state_next           = state;
    head_tok             = '0;
    head_tok.key         = item.region_key;
    head_tok.found       = found;
    head_tok.cur_slot    = cur_slot;
    head_tok.prior_slot  = prior_slot;
    head_tok.prior_valid = prior_valid;
    head_tok.do_score    = prior_valid && found;
    head_tok.time_val    = item.elapsed_time;
    head_tok.prod_val    = prod;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_LAUNCH_SEARCH;
        end
      end
      ST_LAUNCH_SEARCH: begin
        head_tok.vld   = 1'b1;
        head_tok.found = 1'b0;
        state_next     = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (tail_tok.vld) begin
          if (!tail_tok.found && table_is_full) begin
            state_next = ST_DELIVER;
          end else begin
            state_next = ST_LAUNCH_UPDATE;
          end
        end
      end
      ST_LAUNCH_UPDATE: begin
        head_tok.vld = 1'b1;
        head_tok.upd = 1'b1;
        state_next   = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (tail_tok.vld) begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state: configuration, table fill, previous region, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      core_count  <= CORE_W'(8);
      score_mode  <= 1'b0;
      used_slots  <= '0;
      prior_slot  <= '0;
      prior_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_CORE_COUNT: core_count <= cfg_data;
          CFG_SCORE_MODE: score_mode <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (state == ST_UPDATE && tail_tok.vld) begin
        if (!found) begin
          used_slots <= used_slots + CNT_W'(1);
        end
        prior_slot  <= cur_slot;
        prior_valid <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    start_threads <= start_count(core_count);
    if (in_accept) begin
      item <= in_data;
      prod <= SCORE_W'(in_data.elapsed_time) * SCORE_W'(in_data.energy_used);
    end
    if (state == ST_SEARCH && tail_tok.vld) begin
      found <= tail_tok.found;
      if (tail_tok.found) begin
        cur_slot <= tail_tok.cur_slot;
      end else begin
        cur_slot <= used_slots[SLOT_W-1:0];
      end
      result.thread_count <= {1'b0, core_count};
      result.region_slot  <= '0;
      result.table_full   <= 1'b1;
    end
    if (state == ST_UPDATE && tail_tok.vld) begin
      result.thread_count <= tail_tok.result;
      result.region_slot  <= SLOT_OUT_W'(cur_slot);
      result.table_full   <= 1'b0;
    end
    if (out_load) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// File: src/region_thread_count_search.sv
// Region thread-count search, top level.
//
// Input channel in_valid/in_stall/in_data carries a region key with the time
// and energy of the region just left; one transaction yields exactly one
// result on out_valid/out_stall/out_data: thread count, slot and a table-full
// flag. Configuration is written through cfg_wr_en/cfg_index/cfg_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce (index 0 core count, index 1 score mode). The result is
// valid after a search transaction walks the row of slot cells, one cell per
// cycle, then an update transaction walks it again. A full table with a new
// key skips the second walk. One item is in work at a time; the next is
// accepted when the controller is idle, even while the previous result waits
// in the output register. Reset empties the table, forgets the previous
// region and sets core count 8, score mode 0. When the receiver stalls, the
// result stays in the output register and a finished later result waits
// until that one is taken.
// Depends on rtcs_pkg, rtcs_cell and rtcs_ctrl.
`default_nettype none

module region_thread_count_search
  import rtcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_index,
  input  wire logic [CORE_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data
);

  bcast_t bcast;
  token_t chain [REGION_SLOTS+1];

  rtcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .bcast     (bcast),
    .head_tok  (chain[0]),
    .tail_tok  (chain[REGION_SLOTS])
  );

  // Row of slot cells; the token moves one cell per cycle.
  for (genvar g = 0; g < REGION_SLOTS; g++) begin : g_cell
    rtcs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (SLOT_W'(g)),
      .bcast      (bcast),
      .tok_in     (chain[g]),
      .tok_out    (chain[g+1])
    );
  end

endmodule

`default_nettype wire

// File: src/rtcs_checker.sv
// Port-level checker for the region thread-count search, with its bind.
// Depends on rtcs_pkg and region_thread_count_search_assert.svh.
`default_nettype none

`include "region_thread_count_search_assert.svh"

module rtcs_checker
  import rtcs_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire out_item_t         out_data
);

  // A stalled result stays offered and unchanged.
  `RTCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `RTCS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))

  // A full-table answer always names slot zero.
  `RTCS_ASSERT_SAME(a_full_slot, out_valid && out_data.table_full, out_data.region_slot == '0)

  // After a transaction is taken the block is busy with it.
  `RTCS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind region_thread_count_search rtcs_checker u_rtcs_checker (.*);

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench of the region thread-count search.
// Drives region entries, predicts each answer with a local table model and
// compares results field by field; depends on rtcs_pkg and the top level.
`timescale 1ns / 1ps

module testbench;
  import rtcs_pkg::*;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic              cfg_index;
  logic [CORE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;

  region_thread_count_search DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state: a copy of the region table and the settings.
  logic [CORE_W-1:0]  m_cores;
  logic               m_mode;
  logic [KEY_W-1:0]   m_key     [REGION_SLOTS];
  phase_t             m_phase   [REGION_SLOTS];
  logic               m_smode   [REGION_SLOTS];
  logic [THR_W-1:0]   m_thr     [REGION_SLOTS];
  logic [THR_W-1:0]   m_last    [REGION_SLOTS];
  logic [THR_W-1:0]   m_best    [REGION_SLOTS];
  logic [THR_W-1:0]   m_step    [REGION_SLOTS];
  logic [SCORE_W-1:0] m_bscore  [REGION_SLOTS];
  int                 m_used;
  int                 m_prior;
  bit                 m_prior_ok;

  in_item_t  pending_items[$];
  out_item_t expected_answers[$];
  int        errors;
  bit        quiet;
  bit        hold_sender;
  bit        in_taken;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic logic [THR_W-1:0] first_count();
    logic [CORE_W-1:0] v;
    v = m_cores;
    while (v != 2 && v != 3 && v != 5) begin
      if (v < 2) return THR_W'(1);
      v = v >> 1;
    end
    return THR_W'(v);
  endfunction

  function automatic void next_step(int s, logic [THR_W-1:0] st);
    m_step[s]  = st;
    m_phase[s] = (st <= 1) ? PH_S3 : PH_S2;
  endfunction

  // Score the region just left and advance its search.
  function automatic void score_region(int s, logic [31:0] t, logic [31:0] e);
    logic [SCORE_W-1:0] sc;
    logic [THR_W-1:0]   th;
    logic [THR_W-1:0]   st;
    logic [10:0]        dbl;
    th = m_thr[s];
    dbl = {th, 1'b0};
    if (m_smode[s]) begin
      sc = 64'(t) * 64'(e);
      if (sc == 0) begin
        m_phase[s] = PH_REPEAT;
        m_smode[s] = 1'b0;
      end
    end else begin
      sc = 64'(t);
    end
    case (m_phase[s])
      PH_REPEAT: begin
        m_phase[s] = PH_S0;
        m_thr[s]   = first_count();
        m_last[s]  = m_thr[s];
      end
      PH_S0: begin
        m_bscore[s] = sc;
        m_best[s]   = th;
        m_thr[s]    = th << 1;
        m_phase[s]  = PH_S1;
      end
      PH_S1: begin
        st = m_last[s] >> 1;
        if (sc < m_bscore[s]) begin
          m_bscore[s] = sc;
          m_best[s]   = th;
          if (dbl <= 11'(m_cores)) begin
            m_last[s] = th;
            m_thr[s]  = th << 1;
          end else begin
            m_thr[s] = th - st;
            next_step(s, st);
          end
        end else begin
          if (m_best[s] == THR_W'(m_cores >> 1)) m_thr[s] = th - st;
          else m_thr[s] = th + st;
          next_step(s, st);
        end
      end
      PH_S2: begin
        st = m_step[s] >> 1;
        if (!(m_bscore[s] < sc)) begin
          m_best[s]   = th;
          m_bscore[s] = sc;
        end
        m_thr[s] = th + st;
        next_step(s, st);
      end
      PH_S3: begin
        if (sc < m_bscore[s]) m_best[s] = th;
        m_phase[s] = PH_END;
      end
      default: ;
    endcase
  endfunction

  function automatic out_item_t predict_answer(in_item_t it);
    out_item_t r;
    int cur;
    bit hit;
    hit = 1'b0;
    cur = 0;
    for (int i = 0; i < m_used; i++)
      if (!hit && m_key[i] == it.region_key) begin
        cur = i;
        hit = 1'b1;
      end
    r.table_full = 1'b0;
    if (!hit) begin
      if (m_used >= REGION_SLOTS) begin
        r.thread_count = THR_W'(m_cores);
        r.region_slot  = '0;
        r.table_full   = 1'b1;
        return r;
      end
      cur = m_used;
      m_key[cur]   = it.region_key;
      m_phase[cur] = PH_START;
      m_smode[cur] = m_mode;
      m_thr[cur]   = THR_W'(m_cores);
      m_used++;
    end
    if (!m_prior_ok) begin
      m_phase[cur]   = PH_REPEAT;
      r.thread_count = THR_W'(m_cores);
    end else begin
      if (m_phase[m_prior] != PH_END && m_phase[cur] != PH_START)
        score_region(m_prior, it.elapsed_time, it.energy_used);
      if (m_phase[cur] == PH_END) begin
        r.thread_count = m_best[cur];
      end else if (m_phase[cur] == PH_START) begin
        m_phase[cur]   = PH_REPEAT;
        r.thread_count = THR_W'(m_cores);
      end else begin
        r.thread_count = m_thr[cur];
      end
    end
    m_prior    = cur;
    m_prior_ok = 1'b1;
    r.region_slot = SLOT_OUT_W'(cur);
    return r;
  endfunction

  // Driver: one item at a time, inputs change on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (pending_items.size() > 0 && !hold_sender &&
                 (quiet || $urandom_range(99) >= 6)) begin
      in_data  <= pending_items.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
    out_stall <= rst ? 1'b0 : (!quiet && $urandom_range(99) < 6);
  end

  // Predict on acceptance at the rising edge.
  always @(posedge clk) begin
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken)
      expected_answers.push_back(predict_answer(in_data));
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = expected_answers.pop_front();
        if (out_data.thread_count != want.thread_count)
          report($sformatf("thread_count got %0d want %0d",
                           out_data.thread_count, want.thread_count));
        if (out_data.region_slot != want.region_slot)
          report($sformatf("region_slot got %0d want %0d",
                           out_data.region_slot, want.region_slot));
        if (out_data.table_full != want.table_full)
          report($sformatf("table_full got %0d want %0d",
                           out_data.table_full, want.table_full));
      end
    end
  end

  function automatic in_item_t make_item(logic [KEY_W-1:0] k, logic [31:0] t,
                                         logic [31:0] e);
    in_item_t it;
    it.region_key   = k;
    it.elapsed_time = t;
    it.energy_used  = e;
    return it;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  // Wait until every expectation has been met, then longer than one transaction takes.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (2 * REGION_SLOTS + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CORE_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_CORE_COUNT) m_cores = v;
    else m_mode = v[0];
  endtask

  // A pool of keys revisited so regions walk their whole search.
  task automatic random_phase(int n, int pool);
    logic [KEY_W-1:0] keys[64];
    logic [31:0] t;
    for (int i = 0; i < 64; i++) keys[i] = KEY_W'({$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      t = rand_val();
      if ($urandom_range(9) == 0)
        pending_items.push_back(make_item(KEY_W'({$urandom, $urandom}), t,
                                          rand_val()));
      else
        pending_items.push_back(make_item(keys[6'($urandom_range(pool - 1))], t,
                                          rand_val()));
    end
  endtask

  initial begin
    errors = 0; quiet = 1'b0; hold_sender = 1'b0; in_taken = 1'b0;
    m_cores = CORE_W'(8); m_mode = 1'b0; m_used = 0; m_prior = 0;
    m_prior_ok = 1'b0;
    for (int i = 0; i < REGION_SLOTS; i++) begin
      m_key[i] = '0; m_phase[i] = PH_START; m_smode[i] = 1'b0;
      m_thr[i] = THR_W'(8);
      m_last[i] = '0; m_best[i] = '0; m_step[i] = '0; m_bscore[i] = '0;
    end
    rst = 1'b1; cfg_wr_en = 1'b0; cfg_index = CFG_CORE_COUNT; cfg_data = '0;
    in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: one region searched to its end, extremes of the fields.
    for (int i = 0; i < 12; i++)
      pending_items.push_back(make_item(48'h1, 32'(100 - 7 * i), 32'd3));
    pending_items.push_back(make_item('1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item('0, 32'd0, 32'd0));
    pending_items.push_back(make_item(48'h1, 32'd5, 32'd0));
    drain();
    // Energy-delay mode with zero products, core counts 256 and 1.
    write_reg(CFG_SCORE_MODE, 1'b1);
    write_reg(CFG_CORE_COUNT, 9'd256);
    for (int i = 0; i < 8; i++)
      pending_items.push_back(make_item(48'h22, 32'(i * 3), 32'(i & 1)));
    drain();
    write_reg(CFG_CORE_COUNT, 9'd1);
    random_phase(100, 4);
    drain();

    // Random phases over several settings; one fills the table.
    write_reg(CFG_CORE_COUNT, 9'd511);
    write_reg(CFG_SCORE_MODE, 1'b0);
    random_phase(300, 8);
    drain();
    write_reg(CFG_CORE_COUNT, 9'($urandom_range(1, 256)));
    write_reg(CFG_SCORE_MODE, 1'b1);
    quiet = 1'b1;
    random_phase(300, 6);
    drain();
    quiet = 1'b0;
    write_reg(CFG_CORE_COUNT, 9'd12);
    random_phase(400, 64);
    for (int i = 0; i < 80; i++)
      pending_items.push_back(make_item(KEY_W'({$urandom, $urandom}), rand_val(),
                                        rand_val()));
    // Sender holds off until every answer is back.
    hold_sender = 1'b1;
    while (in_valid || expected_answers.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    drain();
    write_reg(CFG_CORE_COUNT, 9'd96);
    write_reg(CFG_SCORE_MODE, 1'b0);
    random_phase(500, 3);
    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/rtcs_pkg.sv
src/rtcs_cell.sv
src/rtcs_ctrl.sv
src/region_thread_count_search.sv
src/rtcs_checker.sv
test/testbench.sv
